// File: rtl/tkil_pkg.sv
// Shared types and constants for the top-K insertion list.
package tkil_pkg;

  localparam int unsigned DEF_MAX_SLOTS = 16;

  localparam int unsigned ID_W    = 22;
  localparam int unsigned CPU_W   = 16;
  localparam int unsigned MEM_W   = 48;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned RANK_W  = 4;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned KEY_W   = MEM_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SORT_BY_MEMORY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAYED_COUNT = 2'd1;

  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd5;

  typedef enum logic [1:0] {
    MODE_OFFER = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [ID_W-1:0]    candidate_id;
    logic [CPU_W-1:0]   cpu_share;
    logic [MEM_W-1:0]   memory_amount;
    logic [IDX_W-1:0]   slot_index;
  } req_t;

  typedef struct packed {
    logic               inserted;
    logic [RANK_W-1:0]  rank;
    logic               read_valid;
    logic [ID_W-1:0]    read_id;
    logic [CPU_W-1:0]   read_cpu;
    logic [MEM_W-1:0]   read_memory;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [CPU_W-1:0]   cpu;
    logic [MEM_W-1:0]   memory;
  } entry_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic               offer;
    logic               clear;
    logic               sort_by_memory;
    logic [KEY_W-1:0]   key;
  } cell_ctrl_t;

endpackage

// File: rtl/tkil_cell.sv
// One slot of the sorted list: holds an entry, compares, shifts or loads.
module tkil_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tkil_pkg::cell_ctrl_t ctrl_i,
  input  logic                 in_use_i,
  input  tkil_pkg::entry_t     new_i,
  input  tkil_pkg::entry_t     prev_i,
  input  logic                 prev_filled_i,
  input  logic                 prev_stop_i,
  input  logic                 stop_above_i,
  output tkil_pkg::entry_t     entry_o,
  output logic                 filled_o,
  output logic                 stop_o,
  output logic                 any_stop_o,
  output logic                 ins_o
);
  import tkil_pkg::*;

  entry_t           entry_q, entry_d;
  logic             filled_q, filled_d;
  logic [KEY_W-1:0] my_key;
  logic             active;

  assign my_key = ctrl_i.sort_by_memory ? entry_q.memory : KEY_W'(entry_q.cpu);

  // Scan stops at a filled slot whose key is not smaller than the new one.
  assign stop_o     = in_use_i && filled_q && (ctrl_i.key <= my_key);
  assign any_stop_o = stop_o || stop_above_i;
  assign active     = ctrl_i.offer && in_use_i && !any_stop_o;
  assign ins_o      = active && prev_stop_i;

  always_comb begin
    entry_d  = entry_q;
    filled_d = filled_q;
    if (ctrl_i.clear) begin
      filled_d = 1'b0;
    end else if (active) begin
      if (prev_stop_i) begin
        entry_d  = new_i;
        filled_d = 1'b1;
      end else begin
        entry_d  = prev_i;
        filled_d = prev_filled_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
    end else begin
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o  = entry_q;
  assign filled_o = filled_q;

endmodule

// File: rtl/top_k_insertion_list.sv
// Top level of the top-K insertion list: config, cell row, read mux, result register.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid_i/in_stall_o | in_req_i  (tkil_pkg::req_t)
//  out     | out | out_valid_o/out_stall_i | out_res_o (tkil_pkg::res_t)
//  cfg     | in  | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// Each accepted request's result appears in the output register the cycle after.
// A new request is taken every cycle while the result register is free or being drained.
// The longest path is the stop chain rippling across the MAX_SLOTS cells.
// Reset empties every slot and sets the count to 5 and the key to cpu share.
// A stalled result holds the input side only while the register is full.
module top_k_insertion_list #(
  parameter int unsigned MAX_SLOTS = tkil_pkg::DEF_MAX_SLOTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tkil_pkg::req_t                    in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tkil_pkg::res_t                    out_res_o,
  input  logic                              cfg_we_i,
  input  logic [tkil_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tkil_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import tkil_pkg::*;

  localparam int unsigned NEED_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned NW     = (NEED_W > CNT_W) ? NEED_W : CNT_W;
  localparam int unsigned RD_N   = (MAX_SLOTS < (1 << IDX_W)) ? MAX_SLOTS : (1 << IDX_W);

  logic             sort_q, sort_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [NW-1:0]    count_ext, n_use;

  logic             accept;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t [MAX_SLOTS-1:0] entry;
  logic [MAX_SLOTS-1:0]   filled, stop, any_stop, ins, in_use;

  // Configuration
  always_comb begin
    sort_d  = sort_q;
    count_d = count_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SORT_BY_MEMORY:  sort_d  = cfg_wdata_i[0];
        CFG_DISPLAYED_COUNT: count_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_q  <= 1'b0;
      count_q <= COUNT_RESET;
    end else begin
      sort_q  <= sort_d;
      count_q <= count_d;
    end
  end

  assign count_ext = NW'(count_q);
  assign n_use     = (count_ext > NW'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : count_ext;

  // Handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Broadcast to the cells
  assign new_entry.id     = in_req_i.candidate_id;
  assign new_entry.cpu    = in_req_i.cpu_share;
  assign new_entry.memory = in_req_i.memory_amount;

  always_comb begin
    ctrl.sort_by_memory = sort_q;
    ctrl.key   = sort_q ? in_req_i.memory_amount : KEY_W'(in_req_i.cpu_share);
    ctrl.offer = accept && (in_req_i.mode == MODE_OFFER) && (ctrl.key != '0);
    ctrl.clear = accept && (in_req_i.mode == MODE_CLEAR);
  end

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    entry_t prev_entry;
    logic   prev_filled, prev_stop, stop_above;

    assign in_use[g] = (n_use > NW'(g));

    if (g == 0) begin : g_head
      // slot 0 takes the new entry whenever nothing at or above it stops the scan
      assign prev_entry  = new_entry;
      assign prev_filled = 1'b1;
      assign prev_stop   = 1'b1;
    end else begin : g_body
      assign prev_entry  = entry[g-1];
      assign prev_filled = filled[g-1];
      assign prev_stop   = stop[g-1];
    end

    if (g == MAX_SLOTS - 1) begin : g_tail
      assign stop_above = 1'b0;
    end else begin : g_inner
      assign stop_above = any_stop[g+1];
    end

    tkil_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .in_use_i      (in_use[g]),
      .new_i         (new_entry),
      .prev_i        (prev_entry),
      .prev_filled_i (prev_filled),
      .prev_stop_i   (prev_stop),
      .stop_above_i  (stop_above),
      .entry_o       (entry[g]),
      .filled_o      (filled[g]),
      .stop_o        (stop[g]),
      .any_stop_o    (any_stop[g]),
      .ins_o         (ins[g])
    );
  end

  // Result
  always_comb begin
    res_d = '0;
    case (in_req_i.mode)
      MODE_OFFER: begin
        res_d.inserted = |ins;
        for (int s = 0; s < MAX_SLOTS; s++) begin
          if (ins[s]) begin
            res_d.rank = res_d.rank | RANK_W'(s);
          end
        end
      end
      MODE_READ: begin
        for (int s = 0; s < RD_N; s++) begin
          if (in_req_i.slot_index == IDX_W'(s) && in_use[s] && filled[s]) begin
            res_d.read_valid  = 1'b1;
            res_d.read_id     = entry[s].id;
            res_d.read_cpu    = entry[s].cpu;
            res_d.read_memory = entry[s].memory;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // Checks
  a_single_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ins))
    else $error("more than one cell took the new entry");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.mode == MODE_CLEAR) |=> (filled == '0))
    else $error("slots still filled after a clear");

  a_zero_key_kept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.mode == MODE_OFFER && ctrl.key == '0) |=> !out_res_o.inserted)
    else $error("zero key inserted");

  a_result_kinds_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_res_o.inserted && out_res_o.read_valid))
    else $error("result flags both an insert and a read");

endmodule

// File: verif/tb.sv
// Self-checking testbench for the top-K insertion list: random rounds against a list predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tkil_pkg::*;

  localparam int unsigned DEPTH          = DEF_MAX_SLOTS;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES    = 48;
  // indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req       = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_t                  res;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  top_k_insertion_list u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_req_i    (req),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_res_o   (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor copy of the list and its registers
  logic             by_memory;
  logic [CNT_W-1:0] shown_count;
  logic             slot_used [DEPTH];
  entry_t           slot_data [DEPTH];

  req_t request_backlog[$];
  res_t predicted_results[$];

  int n_requests = 0;
  int n_results  = 0;
  int n_inserts  = 0;
  int n_hits     = 0;
  int n_settings = 0;
  int errors     = 0;

  int gap_left  = 0;
  bit burst     = 1'b0;
  int hold_left = 0;
  bit hold_req  = 1'b0;
  int run_left  = 0;
  bit run_stall = 1'b0;
  int idle_cycles = 0;

  function automatic res_t apply_to_list(req_t r);
    res_t             out;
    int               n;
    int               pos;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] held;
    out = '0;
    n = (shown_count > DEPTH) ? DEPTH : int'(shown_count);
    case (r.mode)
      MODE_OFFER: begin
        key = by_memory ? r.memory_amount : KEY_W'(r.cpu_share);
        if (key != '0 && n > 0) begin
          // new entry lands below the last filled slot whose key is not smaller
          pos = 0;
          for (int s = 0; s < n; s++) begin
            held = by_memory ? slot_data[s].memory : KEY_W'(slot_data[s].cpu);
            if (slot_used[s] && key <= held) pos = s + 1;
          end
          if (pos < n) begin
            for (int j = n - 2; j >= pos; j--) begin
              slot_used[j + 1] = slot_used[j];
              slot_data[j + 1] = slot_data[j];
            end
            slot_used[pos] = 1'b1;
            slot_data[pos] = '{id: r.candidate_id, cpu: r.cpu_share, memory: r.memory_amount};
            out.inserted = 1'b1;
            out.rank = pos[RANK_W-1:0];
          end
        end
      end
      MODE_CLEAR: foreach (slot_used[s]) slot_used[s] = 1'b0;
      MODE_READ: begin
        if (int'(r.slot_index) < n && slot_used[r.slot_index]) begin
          out.read_valid  = 1'b1;
          out.read_id     = slot_data[r.slot_index].id;
          out.read_cpu    = slot_data[r.slot_index].cpu;
          out.read_memory = slot_data[r.slot_index].memory;
        end
      end
      default: ;
    endcase
    return out;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // keys lean towards zero, the maximum and small values so that ties are common
  function automatic logic [CPU_W-1:0] pick_cpu();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return CPU_W'($urandom_range(1, 6));
      default: return CPU_W'($urandom);
    endcase
  endfunction

  function automatic logic [MEM_W-1:0] pick_mem();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return MEM_W'($urandom_range(1, 6));
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic push_req(mode_e m, logic [ID_W-1:0] id, logic [CPU_W-1:0] cpu,
                          logic [MEM_W-1:0] mem, logic [IDX_W-1:0] idx);
    req_t r;
    r.mode          = m;
    r.candidate_id  = id;
    r.cpu_share     = cpu;
    r.memory_amount = mem;
    r.slot_index    = idx;
    request_backlog.push_back(r);
  endtask

  task automatic push_random(mode_e m);
    push_req(m, ID_W'($urandom), pick_cpu(), pick_mem(), IDX_W'($urandom));
  endtask

  // a round: usually a clear, a run of offers with the odd read, then read-back
  task automatic queue_rounds(int n_items, int clear_pct);
    int left;
    int k;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(1, 100) <= clear_pct) begin
        push_random(MODE_CLEAR);
        left--;
      end
      k = $urandom_range(2, 24);
      repeat (k) begin
        case ($urandom_range(0, 19))
          0:       push_random(mode_e'($urandom_range(0, 3)));
          1, 2, 3: push_random(MODE_READ);
          default: push_random(MODE_OFFER);
        endcase
      end
      left -= k;
      k = $urandom_range(2, 8);
      repeat (k) push_random(MODE_READ);
      left -= k;
    end
  endtask

  task automatic settle();
    while (request_backlog.size() != 0 || req_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
    case (idx)
      CFG_SORT_BY_MEMORY:  by_memory = val[0];
      CFG_DISPLAYED_COUNT: shown_count = val;
      default: ;
    endcase
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    logic took;
    took = req_valid && !req_stall;
    if (took) begin
      predicted_results.push_back(apply_to_list(req));
      n_requests++;
    end
    if (rst_n && (took || !req_valid)) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (request_backlog.size() != 0) begin
        req       <= request_backlog.pop_front();
        req_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    res_t want;
    if (res_valid && !res_stall) begin
      n_results++;
      if (predicted_results.size() == 0) begin
        $display("%0t ns: result with nothing outstanding, actual %h", $time, res);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        check_field("inserted", 64'(want.inserted), 64'(res.inserted));
        check_field("rank", 64'(want.rank), 64'(res.rank));
        check_field("read_valid", 64'(want.read_valid), 64'(res.read_valid));
        check_field("read_id", 64'(want.read_id), 64'(res.read_id));
        check_field("read_cpu", 64'(want.read_cpu), 64'(res.read_cpu));
        check_field("read_memory", 64'(want.read_memory), 64'(res.read_memory));
        if (want.inserted) n_inserts++;
        if (want.read_valid) n_hits++;
      end
    end
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        res_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 2) == 0);
          if (run_stall)
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 3);
          else
            run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
        end
        run_left--;
        res_stall <= run_stall;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
    else if (rst_n) idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no request or result moved for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    by_memory   = 1'b0;
    shown_count = COUNT_RESET;
    foreach (slot_used[s]) begin
      slot_used[s] = 1'b0;
      slot_data[s] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: cpu key, five slots
    push_req(MODE_READ,  22'd0,       16'd0,     48'd0,  4'd0);
    push_req(MODE_OFFER, 22'd1,       16'd0,     '1,     4'd0);  // zero key
    push_req(MODE_OFFER, '1,          '1,        '1,     '1);
    push_req(MODE_OFFER, 22'd0,       16'd1,     48'd0,  4'd0);
    push_req(MODE_OFFER, 22'd2,       16'd1,     48'd7,  4'd0);  // tie goes after
    push_req(MODE_OFFER, 22'd3,       16'd100,   48'd9,  4'd0);
    push_req(MODE_OFFER, 22'd4,       16'd300,   48'd1,  4'd0);
    push_req(MODE_OFFER, 22'd5,       16'd1,     48'd2,  4'd0);  // ties the tail, dropped
    push_req(MODE_OFFER, 22'd6,       16'd2,     48'd3,  4'd0);  // tail falls off
    for (int s = 0; s < 6; s++) push_req(MODE_READ, 22'd0, 16'd0, 48'd0, IDX_W'(s));
    push_req(MODE_READ,  '1,          '1,        '1,     4'd15);
    push_req(MODE_NOP,   '1,          '1,        '1,     '1);
    push_req(MODE_CLEAR, 22'd0,       16'd0,     48'd0,  4'd0);
    push_req(MODE_READ,  22'd0,       16'd0,     48'd0,  4'd0);
    settle();

    write_reg(CFG_SORT_BY_MEMORY, 5'b10101);
    write_reg(CFG_DISPLAYED_COUNT, 5'd16);
    queue_rounds(150, 90);
    settle();

    write_reg(CFG_DISPLAYED_COUNT, 5'd0);
    queue_rounds(30, 50);
    settle();

    // full depth with the count saturated; receiver holds off while requests pile up
    write_reg(CFG_SORT_BY_MEMORY, 5'b11110);
    write_reg(CFG_DISPLAYED_COUNT, 5'd31);
    burst = 1'b1;
    queue_rounds(100, 90);
    hold_req = 1'b1;
    settle();
    burst = 1'b0;

    write_reg(CFG_DISPLAYED_COUNT, 5'd1);
    queue_rounds(60, 90);
    settle();

    write_reg(CFG_SPARE_A, 5'b10101);
    write_reg(CFG_SPARE_B, 5'b01010);
    write_reg(CFG_SORT_BY_MEMORY, 5'b00001);
    write_reg(CFG_DISPLAYED_COUNT, 5'd12);
    queue_rounds(80, 90);
    settle();
    // shrink with no round-opening clears, then grow: offers leave the slots past the short count as they were
    write_reg(CFG_DISPLAYED_COUNT, 5'd3);
    queue_rounds(40, 0);
    settle();
    write_reg(CFG_DISPLAYED_COUNT, 5'd12);
    for (int s = 0; s < DEPTH; s++) push_req(MODE_READ, '1, '1, '1, IDX_W'(s));
    settle();

    repeat (4) begin
      write_reg(CFG_SORT_BY_MEMORY, CFG_DATA_W'($urandom));
      write_reg(CFG_DISPLAYED_COUNT, CFG_DATA_W'($urandom_range(0, 31)));
      queue_rounds(40, 80);
      settle();
    end

    $display("Covered %0d requests in all four modes over %0d register writes, counts 0 to 31.",
             n_requests, n_settings);
    $display("Checked %0d results: %0d insertions, %0d filled-slot reads, %0d mismatches.",
             n_results, n_inserts, n_hits, errors);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
